### sv/bfet_pkg.sv
// Package for the best-fit extract table: operation and status codes,
// the sequencer state type and the packed input and result words.
// No dependencies.
package bfet_pkg;

    localparam logic [1:0] OP_ADD         = 2'd0;
    localparam logic [1:0] OP_TAKE_WEIGHT = 2'd1;
    localparam logic [1:0] OP_TAKE_VOLUME = 2'd2;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TAKEN = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam int TICKET_BITS = 32;
    localparam int FIELD_BITS  = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_MOVE
    } t_state;

    typedef struct packed {
        logic [1:0]            operation;
        logic [FIELD_BITS-1:0] item_weight;
        logic [FIELD_BITS-1:0] item_volume;
        logic [FIELD_BITS-1:0] threshold;
    } t_in_word;

    typedef struct packed {
        logic [1:0]             status;
        logic [TICKET_BITS-1:0] ticket;
    } t_out_word;

endpackage

### sv/best_fit_extract_table_core.sv
// Best-fit extract table: a memory-held table of items with add and
// best-fit take. Depends on bfet_pkg.
//
// A user issues one word at a time with start while busy is low. An add,
// an add to a full table, an unused operation code and a take on an empty
// table are finished at once: the result word appears with o_done in the
// cycle after acceptance and busy never rises, so a new word may be issued
// in that same cycle. A take on a table that holds N entries scans the
// table memory through its single read port, one slot per cycle from the
// newest slot down, so busy stays high through the N scan reads, a drain
// state that compares the last read while the last entry is fetched, and a
// move state that writes that entry into the freed slot when a fit was
// found; the result shows with o_done in the cycle in which busy falls. The
// result strobe lasts exactly one cycle and cannot be held off by the
// receiver, so it must be captured when it appears. No clearing pass is
// needed after reset: only slots below the entry count are read.
module best_fit_extract_table_core
    import bfet_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KB = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int MW = 2 * VALUE_BITS + TICKET_BITS;

    // Memory word layout: {weight, volume, ticket}.
    localparam int TK_LO = 0;
    localparam int VO_LO = TICKET_BITS;
    localparam int WE_LO = TICKET_BITS + VALUE_BITS;

    logic [MW-1:0] r_mem [ENTRIES];
    logic [MW-1:0] r_q;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [TICKET_BITS-1:0] r_ticket_next, n_ticket_next;
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_done, n_done;
    t_out_word              r_result, n_result;
    logic                   r_found, n_found;
    logic [AW-1:0]          r_best_slot, n_best_slot;
    logic [VALUE_BITS-1:0]  r_best_val, n_best_val;
    logic [TICKET_BITS-1:0] r_best_ticket, n_best_ticket;
    logic                   r_by_volume, n_by_volume;
    logic [VALUE_BITS-1:0]  r_thr, n_thr;
    logic                   r_cmp_en, n_cmp_en;
    logic [AW-1:0]          r_q_slot;

    logic                   accept;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [AW-1:0]          last_slot;
    logic [VALUE_BITS-1:0]  q_val;
    logic                   hit;
    logic [VALUE_BITS-1:0]  in_weight, in_volume, in_thr;

    assign accept    = start && (r_state == S_IDLE);
    assign last_slot = AW'(r_count - CW'(1));
    assign in_weight = VALUE_BITS'(i_word.item_weight[KB-1:0]);
    assign in_volume = VALUE_BITS'(i_word.item_volume[KB-1:0]);
    assign in_thr    = VALUE_BITS'(i_word.threshold[KB-1:0]);

    // The read data belongs to the slot issued in the previous cycle. Since the
    // scan runs downward and only a strictly smaller value replaces the
    // pick, the highest slot wins a tie.
    assign q_val = r_by_volume ? r_q[VO_LO +: VALUE_BITS] : r_q[WE_LO +: VALUE_BITS];
    assign hit   = r_cmp_en && (q_val >= r_thr) && (!r_found || (q_val < r_best_val));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (r_count != '0) &&
                    (i_word.operation inside {OP_TAKE_WEIGHT, OP_TAKE_VOLUME})) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MOVE;
            S_MOVE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_count       = r_count;
        n_ticket_next = r_ticket_next;
        n_addr        = r_addr;
        n_done        = 1'b0;
        n_result      = r_result;
        n_found       = r_found;
        n_best_slot   = r_best_slot;
        n_best_val    = r_best_val;
        n_best_ticket = r_best_ticket;
        n_by_volume   = r_by_volume;
        n_thr         = r_thr;
        n_cmp_en      = (r_state == S_SCAN);
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_count);
        mem_wdata     = {in_weight, in_volume, r_ticket_next};
        mem_raddr     = r_addr;

        if (hit) begin
            n_found       = 1'b1;
            n_best_slot   = r_q_slot;
            n_best_val    = q_val;
            n_best_ticket = r_q[TK_LO +: TICKET_BITS];
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_found     = 1'b0;
                    n_by_volume = (i_word.operation == OP_TAKE_VOLUME);
                    n_thr       = in_thr;
                    n_addr      = last_slot;
                    case (i_word.operation)
                        OP_ADD: begin
                            n_done = 1'b1;
                            if (r_count >= CW'(ENTRIES)) begin
                                n_result = '{status: ST_FULL, ticket: '0};
                            end else begin
                                mem_we        = 1'b1;
                                n_count       = r_count + CW'(1);
                                n_ticket_next = r_ticket_next + TICKET_BITS'(1);
                                n_result      = '{status: ST_ADDED, ticket: r_ticket_next};
                            end
                        end
                        OP_TAKE_WEIGHT, OP_TAKE_VOLUME: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_result = '{status: ST_NONE, ticket: '0};
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_NONE, ticket: '0};
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr != '0) begin
                    n_addr = r_addr - AW'(1);
                end
            end
            S_DRAIN: begin
                // Slot 0 is compared now while the last entry is fetched.
                mem_raddr = last_slot;
            end
            S_MOVE: begin
                // The scan and the move are strictly ordered by the
                // sequencer, so no scan read can overlap this write.
                n_done = 1'b1;
                if (r_found) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_best_slot;
                    mem_wdata = r_q;
                    n_count   = r_count - CW'(1);
                    n_result  = '{status: ST_TAKEN, ticket: r_best_ticket};
                end else begin
                    n_result  = '{status: ST_NONE, ticket: '0};
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_q      <= r_mem[mem_raddr];
        r_q_slot <= mem_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_ticket_next <= '0;
            r_done        <= 1'b0;
            r_found       <= 1'b0;
            r_cmp_en      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_ticket_next <= n_ticket_next;
            r_done        <= n_done;
            r_found       <= n_found;
            r_cmp_en      <= n_cmp_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr        <= n_addr;
        r_result      <= n_result;
        r_best_slot   <= n_best_slot;
        r_best_val    <= n_best_val;
        r_best_ticket <= n_best_ticket;
        r_by_volume   <= n_by_volume;
        r_thr         <= n_thr;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### sv/bfet_checker.sv
// Port-level checker for the best-fit extract table, bound to the top level.
// Depends on bfet_pkg and best_fit_extract_table_core.
module bfet_checker
    import bfet_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_word  i_word,
    input logic      busy,
    input logic      o_done,
    input t_out_word o_result
);

    // An accepted word either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted word neither finished nor started a scan");

    // A result word only shows once the block has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Refusals carry no ticket.
    a_zero_ticket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_result.status == ST_FULL) || (o_result.status == ST_NONE)))
        |-> (o_result.ticket == '0))
        else $error("nonzero ticket on a refused word");

    // The block only gets busy because a word was accepted.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted word");

    // Once a scan has ended the result shows in the cycle in which busy falls.
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("scan ended without a result word");

endmodule

bind best_fit_extract_table_core bfet_checker u_bfet_checker (.*);

### tb/sv/tb_best_fit_extract_table_core.sv
// Self-checking testbench for best_fit_extract_table_core: directed and random
// add and take words, checked against an in-bench model of the item table.
// Depends on bfet_pkg and best_fit_extract_table_core.
module tb_best_fit_extract_table_core;
    import bfet_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 64;
    localparam int VALUE_BITS  = 16;
    localparam int ITEM_TARGET = 1750;
    // The last stretch of words is driven back to back with no idle bursts.
    localparam int CALM_TAIL   = 150;
    localparam int REPORT_MAX  = 10;

    // The package names no code for the fourth operation; the block answers it with ST_NONE and leaves the table alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [FIELD_BITS-1:0] VALUE_MASK =
        FIELD_BITS'((64'd1 << VALUE_BITS) - 64'd1);

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  i_word  = '0;
    logic      busy;
    logic      o_done;
    t_out_word o_result;

    best_fit_extract_table_core #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_word   (i_word),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Words waiting to be issued, and the results that accepted words still owe.
    t_in_word  queued_words[$];
    t_out_word awaited_results[$];

    // Shadow copy of the item table, updated in acceptance order.
    logic [FIELD_BITS-1:0]  shelf_weight[ENTRIES];
    logic [FIELD_BITS-1:0]  shelf_volume[ENTRIES];
    logic [TICKET_BITS-1:0] shelf_ticket[ENTRIES];
    int                     shelf_count    = 0;
    logic [TICKET_BITS-1:0] ticket_counter = '0;

    int total_words    = 0;
    int accepted_words = 0;
    int idle_left      = 0;
    int error_count    = 0;
    int checked_count  = 0;
    int added_count    = 0;
    int full_count     = 0;
    int taken_count    = 0;
    int miss_count     = 0;

    // Applies one accepted word to the shadow table and returns the result
    // the block must produce for it. A take scans from the newest slot down
    // and only a strictly smaller value replaces the pick, so on a tie the
    // highest slot wins. The chosen entry is refilled from the last slot;
    // when the chosen entry is the last one it is simply dropped.
    function automatic t_out_word table_outcome(t_in_word w);
        t_out_word             r;
        logic [FIELD_BITS-1:0] limit;
        logic [FIELD_BITS-1:0] v;
        logic [FIELD_BITS-1:0] best_val;
        int                    best_slot;
        bit                    found;
        int                    last;
        r.status  = ST_NONE;
        r.ticket  = '0;
        limit     = w.threshold & VALUE_MASK;
        found     = 1'b0;
        best_val  = '0;
        best_slot = 0;
        case (w.operation)
            OP_ADD: begin
                if (shelf_count >= ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    shelf_weight[shelf_count] = w.item_weight & VALUE_MASK;
                    shelf_volume[shelf_count] = w.item_volume & VALUE_MASK;
                    shelf_ticket[shelf_count] = ticket_counter;
                    shelf_count               = shelf_count + 1;
                    r.status                  = ST_ADDED;
                    r.ticket                  = ticket_counter;
                    ticket_counter            = ticket_counter + TICKET_BITS'(1);
                end
            end
            OP_TAKE_WEIGHT, OP_TAKE_VOLUME: begin
                for (int i = shelf_count; i > 0; i--) begin
                    v = (w.operation == OP_TAKE_WEIGHT) ? shelf_weight[i-1]
                                                        : shelf_volume[i-1];
                    if (v >= limit && (!found || v < best_val)) begin
                        best_val  = v;
                        best_slot = i - 1;
                        found     = 1'b1;
                    end
                end
                if (found) begin
                    r.status                = ST_TAKEN;
                    r.ticket                = shelf_ticket[best_slot];
                    last                    = shelf_count - 1;
                    shelf_weight[best_slot] = shelf_weight[last];
                    shelf_volume[best_slot] = shelf_volume[last];
                    shelf_ticket[best_slot] = shelf_ticket[last];
                    shelf_count             = last;
                end
            end
            default: begin
                // The unused operation code leaves the table alone.
            end
        endcase
        return r;
    endfunction

    // Stimulus helpers. Only words the block acts on count toward the target.
    task automatic queue_add(input logic [15:0] wt, input logic [15:0] vol);
        t_in_word w;
        w.operation   = OP_ADD;
        w.item_weight = wt;
        w.item_volume = vol;
        w.threshold   = 16'($urandom);
        queued_words  = {queued_words, w};
        total_words = total_words + 1;
    endtask

    task automatic queue_take(input logic [1:0] op, input logic [15:0] thr);
        t_in_word w;
        w.operation   = op;
        w.item_weight = 16'($urandom);
        w.item_volume = 16'($urandom);
        w.threshold   = thr;
        queued_words  = {queued_words, w};
        total_words = total_words + 1;
    endtask

    task automatic queue_unused();
        t_in_word w;
        w.operation   = OP_UNUSED;
        w.item_weight = 16'($urandom);
        w.item_volume = 16'($urandom);
        w.threshold   = 16'($urandom);
        queued_words  = {queued_words, w};
    endtask

    // Mode 0 keeps values in a narrow band so ties and exact hits are common,
    // mode 1 spreads them over the full range, mode 2 sticks to the edges.
    function automatic logic [15:0] pick_value(input int mode);
        logic [15:0] edges[4];
        edges = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
        case (mode)
            0:       return 16'($urandom_range(0, 15));
            1:       return 16'($urandom);
            default: return edges[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic logic [1:0] pick_take();
        return ($urandom_range(0, 1) == 0) ? OP_TAKE_WEIGHT : OP_TAKE_VOLUME;
    endfunction

    // Driver: changes inputs on the falling edge. Idle bursts can start at any
    // point, including while the block is busy with a scan, and stop once the
    // run reaches its last stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n || queued_words.size() == 0) begin
            start <= 1'b0;
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start     <= 1'b0;
        end else if (accepted_words + CALM_TAIL < total_words
                     && $urandom_range(0, 9) == 0) begin
            idle_left <= $urandom_range(0, 17);
            start     <= 1'b0;
        end else begin
            start  <= 1'b1;
            i_word <= queued_words[0];
        end
    end

    // Monitor and predictor: sample on the rising edge. A result is checked
    // before the word accepted at the same edge is predicted, since a result
    // always belongs to an earlier word.
    always @(posedge i_clk) begin : monitor
        t_in_word  w;
        t_out_word want;
        if (i_rst_n) begin
            if (o_done) begin
                checked_count = checked_count + 1;
                if (awaited_results.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_MAX) begin
                        $display("ERROR: unexpected result status %0d ticket %0d",
                                 o_result.status, o_result.ticket);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.status !== want.status
                        || o_result.ticket !== want.ticket) begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_MAX) begin
                            $display("ERROR: result %0d: status %0d ticket %0d, expected status %0d ticket %0d",
                                     checked_count, o_result.status, o_result.ticket,
                                     want.status, want.ticket);
                        end
                    end
                end
            end
            if (start && !busy) begin
                w               = queued_words.pop_front();
                want            = table_outcome(w);
                awaited_results = {awaited_results, want};
                if (w.operation != OP_UNUSED) begin
                    accepted_words = accepted_words + 1;
                end
                case (want.status)
                    ST_ADDED: added_count = added_count + 1;
                    ST_FULL:  full_count  = full_count + 1;
                    ST_TAKEN: taken_count = taken_count + 1;
                    default:  miss_count  = miss_count + 1;
                endcase
            end
        end
    end

    initial begin : stimulus
        int mode;
        int seg;
        int n;
        int pick;

        // Directed part. Takes on an empty table, at both threshold extremes.
        queue_take(OP_TAKE_WEIGHT, 16'h0000);
        queue_take(OP_TAKE_VOLUME, 16'hFFFF);
        queue_unused();
        // Field extremes, then equal values to force ties.
        queue_add(16'h0000, 16'hFFFF);
        queue_add(16'hFFFF, 16'h0000);
        queue_add(16'h0005, 16'h0005);
        queue_add(16'h0005, 16'h0005);
        queue_add(16'h0005, 16'h0007);
        queue_add(16'hAAAA, 16'h5555);
        queue_add(16'h5555, 16'hAAAA);
        // Tie on weight 5: the newest of the three must go.
        queue_take(OP_TAKE_WEIGHT, 16'h0005);
        queue_take(OP_TAKE_WEIGHT, 16'hFFFF);
        queue_take(OP_TAKE_VOLUME, 16'h0006);
        queue_take(OP_TAKE_WEIGHT, 16'h0000);
        queue_take(OP_TAKE_VOLUME, 16'hFFFF);
        queue_take(OP_TAKE_VOLUME, 16'hFFFF);
        queue_unused();
        // A unique best fit sitting in the newest slot is simply dropped.
        queue_add(16'h0064, 16'h0064);
        queue_take(OP_TAKE_WEIGHT, 16'h0064);
        queue_take(OP_TAKE_VOLUME, 16'h0000);
        queue_take(OP_TAKE_WEIGHT, 16'h0000);
        queue_take(OP_TAKE_VOLUME, 16'h0000);
        queue_take(OP_TAKE_WEIGHT, 16'h0000);

        // Random part, built from runs: filling runs, some long enough to reach a
        // full table, draining runs, mixed traffic and a little noise.
        while (total_words < ITEM_TARGET) begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(0, 9);
            if (seg < 3) begin
                n = $urandom_range(8, 72);
                repeat (n) queue_add(pick_value(mode), pick_value(mode));
            end else if (seg < 6) begin
                n = $urandom_range(4, 40);
                repeat (n) begin
                    queue_take(pick_take(), ($urandom_range(0, 3) == 0)
                                            ? 16'h0000 : pick_value(mode));
                end
            end else if (seg < 9) begin
                n = $urandom_range(10, 60);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50) begin
                        queue_add(pick_value(mode), pick_value(mode));
                    end else if (pick < 95) begin
                        queue_take(pick_take(), pick_value(mode));
                    end else begin
                        queue_unused();
                    end
                end
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) queue_unused();
                queue_take(pick_take(), 16'($urandom));
            end
        end

        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then keep sampling for stray results for longer than one full scan.
        while (queued_words.size() != 0 || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ENTRIES + 8) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            error_count = error_count + awaited_results.size();
        end

        $display("Covered %0d table words: %0d added, %0d refused as full, %0d taken, %0d with no fit.",
                 checked_count, added_count, full_count, taken_count, miss_count);
        $display("Mismatches or stray results: %0d.", error_count);
        if (error_count == 0) begin
            $display("best_fit_extract_table_core verification clean");
        end else begin
            $display("best_fit_extract_table_core verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial begin
        #10_000_000;
        $display("best_fit_extract_table_core verification failed");
        $finish;
    end

endmodule

### best_fit_extract_table_core.f
sv/bfet_pkg.sv
sv/best_fit_extract_table_core.sv
sv/bfet_checker.sv
tb/sv/tb_best_fit_extract_table_core.sv
